/* design/edd_pkg.sv */
// Shared constants, types and saturation helper for the error diffusion dither.
package edd_pkg;

	localparam int MaxWidthDefault = 1024;
	localparam int LwWidth = 11;
	localparam int ThrWidth = 12;
	localparam int CfgDataWidth = 12;
	localparam int ErrWidth = 16;
	localparam int WideWidth = 20;

	localparam logic [LwWidth-1:0] LwReset = 11'd1024;
	localparam logic [ThrWidth-1:0] ThrReset = 12'd2040;
	localparam logic signed [WideWidth-1:0] WhiteLevel = 20'sd4080;

	localparam logic REG_LINE_WIDTH = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	typedef logic signed [ErrWidth-1:0] err_t;

	typedef struct packed {
		logic dot;
		err_t e7;
		err_t e3;
		err_t e5;
		err_t e1;
	} edd_share_t;

	function automatic err_t sat16(input logic signed [WideWidth-1:0] v);
		if (v > 20'sd32767) begin
			return 16'sh7fff;
		end else if (v < -20'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[ErrWidth-1:0];
		end
	endfunction

endpackage

/* design/edd_kernel.sv */
// Decision and error split for one pixel: adds diffused error, thresholds, weights the residue.
module edd_kernel (
	input  logic [7:0]                    pixel,
	input  edd_pkg::err_t                 right_in,
	input  edd_pkg::err_t                 above_in,
	input  logic                          use_above,
	input  logic [edd_pkg::ThrWidth-1:0]  threshold,
	output edd_pkg::edd_share_t           share
);
	import edd_pkg::*;

	err_t sum1;
	err_t sum2;
	logic signed [WideWidth-1:0] thr_w;
	logic signed [WideWidth-1:0] err_w;
	logic signed [WideWidth-1:0] m7;
	logic signed [WideWidth-1:0] m3;
	logic signed [WideWidth-1:0] m5;
	logic signed [WideWidth-1:0] s7;
	logic signed [WideWidth-1:0] s3;
	logic signed [WideWidth-1:0] s5;
	logic signed [WideWidth-1:0] s1;
	logic dot;

	assign sum1 = sat16($signed({8'd0, pixel, 4'd0}) + WideWidth'(right_in));
	assign sum2 = use_above ? sat16(WideWidth'(sum1) + WideWidth'(above_in)) : sum1;
	assign thr_w = $signed({8'd0, threshold});
	assign dot = WideWidth'(sum2) > thr_w;
	assign err_w = WideWidth'(sum2) - (dot ? WhiteLevel : '0);

	assign m7 = (err_w <<< 3) - err_w;
	assign m3 = (err_w <<< 1) + err_w;
	assign m5 = (err_w <<< 2) + err_w;
	assign s7 = m7 >>> 4;
	assign s3 = m3 >>> 4;
	assign s5 = m5 >>> 4;
	assign s1 = err_w >>> 4;

	assign share.dot = dot;
	assign share.e7 = s7[ErrWidth-1:0];
	assign share.e3 = s3[ErrWidth-1:0];
	assign share.e5 = s5[ErrWidth-1:0];
	assign share.e1 = s1[ErrWidth-1:0];

endmodule

/* design/error_diffusion_dither.sv */
// Top level of the error diffusion dither: row error memory, pixel pipeline and ports.
// An accepted pixel is registered in the first stage, then its result in the output register.
// Throughput: one pixel per cycle unless the output stalls; the row error memory is read at
// acceptance, written back as the pixel leaves stage one, with same-address write forwarding.
// Reset restores the configuration defaults, sets the first-row flag and clears the column,
// carried errors and valid flags.
// The row error memory is not cleared; the first row of each frame ignores its contents.
module error_diffusion_dither #(
	parameter int MAX_WIDTH = edd_pkg::MaxWidthDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [edd_pkg::CfgDataWidth-1:0]  cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // [7:0] pixel
	input  logic                              s_tuser,  // [0] frame_start
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // [0] dot, [7:1] zero
	output logic                              m_tlast   // row_end
);
	import edd_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = (AW + 1 > LwWidth + 1) ? AW + 1 : LwWidth + 1;
	localparam logic [CW-1:0] MaxW = CW'(MAX_WIDTH);

	logic [LwWidth-1:0] line_width_q;
	logic [ThrWidth-1:0] threshold_q;
	logic [AW-1:0] column_q;
	logic first_row_q;

	logic s1_valid_q;
	logic [7:0] pixel_s1;
	logic fs_s1;
	logic first_s1;
	logic last_s1;
	logic [AW-1:0] col_s1;
	err_t nre_rd_s1;
	logic fwd_s1;
	err_t fwd_data_s1;

	err_t rc_q;
	err_t pb_q;
	err_t pbr_q;

	logic pw_valid_q;
	logic [AW-1:0] pw_addr_q;
	err_t pw_data_q;

	logic out_valid_q;
	logic dot_q;
	logic row_end_q;

	err_t nre_mem [MAX_WIDTH];

	logic in_fire;
	logic s1_fire;
	logic [CW-1:0] width_c;
	logic [CW-1:0] lw_ext;
	logic [AW-1:0] in_col;
	logic in_last;
	logic in_first;
	err_t rc_c;
	err_t pb_c;
	err_t pbr_c;
	err_t above_c;
	err_t new_pb;
	edd_share_t share;
	logic we_c;
	logic [AW-1:0] wa_c;
	err_t wd_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LwReset;
			threshold_q <= ThrReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_WIDTH: line_width_q <= cfg_data[LwWidth-1:0];
				REG_THRESHOLD:  threshold_q <= cfg_data[ThrWidth-1:0];
				default:        ;
			endcase
		end
	end

	assign lw_ext = CW'(line_width_q);
	always_comb begin
		if (lw_ext == '0) begin
			width_c = CW'(1);
		end else if (lw_ext > MaxW) begin
			width_c = MaxW;
		end else begin
			width_c = lw_ext;
		end
	end

	assign s1_fire = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_fire;
	assign in_fire = s_tvalid && s_tready;

	assign in_col = s_tuser ? '0 : column_q;
	assign in_first = s_tuser || first_row_q;
	assign in_last = CW'(in_col) >= (width_c - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			first_row_q <= 1'b1;
		end else if (in_fire) begin
			column_q <= in_last ? '0 : in_col + AW'(1);
			first_row_q <= in_last ? 1'b0 : in_first;
		end
	end

	assign rc_c = fs_s1 ? '0 : rc_q;
	assign pb_c = fs_s1 ? '0 : pb_q;
	assign pbr_c = fs_s1 ? '0 : pbr_q;
	assign above_c = fwd_s1 ? fwd_data_s1 : nre_rd_s1;

	edd_kernel u_kernel (
		.pixel     (pixel_s1),
		.right_in  (rc_c),
		.above_in  (above_c),
		.use_above (!first_s1),
		.threshold (threshold_q),
		.share     (share)
	);

	assign new_pb = sat16(WideWidth'(pbr_c) + WideWidth'(share.e5));

	always_comb begin
		we_c = 1'b0;
		wa_c = col_s1;
		wd_c = new_pb;
		if (pw_valid_q) begin
			we_c = 1'b1;
			wa_c = pw_addr_q;
			wd_c = pw_data_q;
		end else if (s1_fire && col_s1 != '0) begin
			we_c = 1'b1;
			wa_c = col_s1 - AW'(1);
			wd_c = sat16(WideWidth'(pb_c) + WideWidth'(share.e3));
		end else if (s1_fire && last_s1) begin
			we_c = 1'b1;
			wa_c = col_s1;
			wd_c = new_pb;
		end
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			nre_mem[wa_c] <= wd_c;
		end
		if (in_fire) begin
			nre_rd_s1 <= nre_mem[in_col];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pixel_s1 <= s_tdata;
			col_s1 <= in_col;
			fs_s1 <= s_tuser;
			first_s1 <= in_first;
			last_s1 <= in_last;
			fwd_s1 <= we_c && (wa_c == in_col);
			fwd_data_s1 <= wd_c;
		end
		if (s1_fire && last_s1) begin
			pw_addr_q <= col_s1;
			pw_data_q <= new_pb;
		end
		if (s1_fire) begin
			dot_q <= share.dot;
			row_end_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			pw_valid_q <= 1'b0;
			rc_q <= '0;
			pb_q <= '0;
			pbr_q <= '0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			pw_valid_q <= s1_fire && last_s1 && (col_s1 != '0);
			if (s1_fire) begin
				if (last_s1) begin
					rc_q <= '0;
					pb_q <= '0;
					pbr_q <= '0;
				end else begin
					rc_q <= share.e7;
					pb_q <= new_pb;
					pbr_q <= share.e1;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'd0, dot_q};
	assign m_tlast = row_end_q;

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		pw_valid_q |-> !(s1_fire && col_s1 != '0))
		else $error("deferred row write collides with a pipeline write");

	a_frame_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && fs_s1) |-> (col_s1 == '0 && first_s1))
		else $error("frame start item not at column zero of a first row");

	a_row_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> (rc_q == '0 && pb_q == '0 && pbr_q == '0 && column_q == '0)
			|| $past(in_fire))
		else $error("carried errors not cleared after row end");

endmodule

/* tb/sv/error_diffusion_dither_test.sv */
// Self-checking testbench for the error diffusion dither: directed table, then random phases.
`timescale 1ns / 1ps

module error_diffusion_dither_test;
	import edd_pkg::*;

	localparam int RowCap = MaxWidthDefault;
	localparam int FullScaleWhite = 4080;
	localparam int RandomPhases = 12;
	localparam int WidePhase = 4;

	typedef struct packed {
		logic dot;
		logic row_end;
	} dot_result_t;

	typedef enum logic [1:0] {STEP_PIXEL, STEP_WIDTH, STEP_THRESHOLD} step_kind_t;

	typedef struct {
		step_kind_t kind;
		int value;
		logic frame_start;
		bit known;
		logic dot;
		logic row_end;
	} dither_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_LINE_WIDTH;
	logic [CfgDataWidth-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;

	// Shadow of the block: row error memory, carried errors and registers.
	err_t row_err_mem [RowCap];
	bit row_seen [RowCap];
	int carry_right = 0;
	int below = 0;
	int below_right = 0;
	int col = 0;
	bit on_first_row = 1'b1;
	logic [LwWidth-1:0] width_reg = LwReset;
	logic [ThrWidth-1:0] thr_reg = ThrReset;

	dot_result_t pending_dots[$];
	dot_result_t oldest_dot;
	int fail_count = 0;
	int burst_left = 0;

	int results_seen = 0;
	int next_hold_at = 300;
	int hold_left = 0;
	int ready_mode = 0;
	int mode_left = 0;

	dither_step_t directed_steps [31] = '{
		'{STEP_WIDTH,     4,    1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     0,    1'b1, 1'b1, 1'b0, 1'b0},
		'{STEP_PIXEL,     255,  1'b0, 1'b1, 1'b1, 1'b0},
		'{STEP_PIXEL,     0,    1'b0, 1'b1, 1'b0, 1'b0},
		'{STEP_PIXEL,     255,  1'b0, 1'b1, 1'b1, 1'b1},
		'{STEP_PIXEL,     0,    1'b0, 1'b1, 1'b0, 1'b0},
		'{STEP_PIXEL,     255,  1'b0, 1'b1, 1'b1, 1'b0},
		'{STEP_PIXEL,     0,    1'b0, 1'b1, 1'b0, 1'b0},
		'{STEP_PIXEL,     255,  1'b0, 1'b1, 1'b1, 1'b1},
		'{STEP_PIXEL,     128,  1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     127,  1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     0,    1'b1, 1'b1, 1'b0, 1'b0},
		'{STEP_PIXEL,     200,  1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     60,   1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     255,  1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     255,  1'b1, 1'b1, 1'b1, 1'b0},
		'{STEP_WIDTH,     1,    1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     100,  1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     255,  1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_WIDTH,     0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_THRESHOLD, 0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     0,    1'b1, 1'b1, 1'b0, 1'b1},
		'{STEP_PIXEL,     1,    1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_THRESHOLD, 4095, 1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_WIDTH,     4,    1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     255,  1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     255,  1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_WIDTH,     2,    1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     17,   1'b0, 1'b0, 1'b0, 1'b0},
		'{STEP_PIXEL,     0,    1'b1, 1'b1, 1'b0, 1'b0},
		'{STEP_THRESHOLD, 2040, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	error_diffusion_dither dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_err(input int v);
		if (v > 32767) begin
			return 32767;
		end else if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	function automatic dot_result_t diffuse_pixel(input logic [7:0] px, input logic fs);
		int w;
		int sum;
		int err;
		int e7;
		int e3;
		int e5;
		int e1;
		dot_result_t res;
		w = int'(width_reg);
		if (w < 1) begin
			w = 1;
		end
		if (w > RowCap) begin
			w = RowCap;
		end
		if (fs) begin
			col = 0;
			carry_right = 0;
			below = 0;
			below_right = 0;
			on_first_row = 1'b1;
		end
		if (col >= RowCap) begin
			col = RowCap - 1;
		end
		res.row_end = (col >= w - 1);
		sum = clamp_err(int'(px) * 16 + carry_right);
		if (!on_first_row) begin
			sum = clamp_err(sum + int'(row_err_mem[col]));
		end
		res.dot = (sum > int'(thr_reg));
		err = sum - (res.dot ? FullScaleWhite : 0);
		// Arithmetic shifts floor towards minus infinity, as the weights require.
		e7 = (err * 7) >>> 4;
		e3 = (err * 3) >>> 4;
		e5 = (err * 5) >>> 4;
		e1 = err >>> 4;
		if (col > 0) begin
			row_err_mem[col - 1] = err_t'(clamp_err(below + e3));
			row_seen[col - 1] = 1'b1;
		end
		below = clamp_err(below_right + e5);
		below_right = e1;
		carry_right = e7;
		if (res.row_end) begin
			row_err_mem[col] = err_t'(below);
			row_seen[col] = 1'b1;
			below = 0;
			below_right = 0;
			carry_right = 0;
			col = 0;
			on_first_row = 1'b0;
		end else begin
			col++;
		end
		return res;
	endfunction

	task automatic push_pixel(input logic [7:0] px, input logic fs, input bit known,
			input logic kdot, input logic kend);
		int gap;
		dot_result_t res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tdata <= px;
		s_tuser <= fs;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		res = diffuse_pixel(px, fs);
		if (known) begin
			res.dot = kdot;
			res.row_end = kend;
		end
		pending_dots.insert(pending_dots.size(), res);
		burst_left--;
	endtask

	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (pending_dots.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_reg(input logic idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataWidth'(val);
		@(posedge clk);
		if (idx == REG_LINE_WIDTH) begin
			width_reg = LwWidth'(val);
		end else begin
			thr_reg = ThrWidth'(val);
		end
	endtask

	task automatic run_random_phase(input int w, input int thr, input int count,
			input bit open_frame);
		logic [7:0] px;
		logic fs;
		int pick;
		settle_block();
		program_reg(REG_LINE_WIDTH, w);
		program_reg(REG_THRESHOLD, thr);
		cfg_we <= 1'b0;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			px = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
			fs = (i == 0) ? open_frame : ($urandom_range(0, 63) == 0);
			// A row entry that has never been written must not be read.
			if (!fs && !on_first_row && !row_seen[col]) begin
				fs = 1'b1;
			end
			push_pixel(px, fs, 1'b0, 1'b0, 1'b0);
		end
	endtask

	initial begin
		int w;
		int thr;
		int pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_steps[i]) begin
			case (directed_steps[i].kind)
				STEP_PIXEL: begin
					push_pixel(8'(directed_steps[i].value), directed_steps[i].frame_start,
						directed_steps[i].known, directed_steps[i].dot,
						directed_steps[i].row_end);
				end
				STEP_WIDTH: begin
					settle_block();
					program_reg(REG_LINE_WIDTH, directed_steps[i].value);
					cfg_we <= 1'b0;
				end
				default: begin
					settle_block();
					program_reg(REG_THRESHOLD, directed_steps[i].value);
					cfg_we <= 1'b0;
				end
			endcase
		end
		for (int p = 0; p < RandomPhases; p++) begin
			pick = $urandom_range(0, 9);
			w = (pick == 0) ? 1 : (pick == 1) ? 0 : (pick < 7) ? $urandom_range(2, 8)
				: $urandom_range(9, 48);
			pick = $urandom_range(0, 7);
			thr = (pick == 0) ? 0 : (pick == 1) ? 4095 : (pick == 2) ? $urandom_range(0, 4095)
				: $urandom_range(1500, 2600);
			if (p == WidePhase) begin
				// Above the maximum, so it acts as a full-width row; one row and a little more.
				run_random_phase(2047, thr, RowCap + 6, 1'b1);
			end else begin
				run_random_phase(w, thr, $urandom_range(15, 40), $urandom_range(0, 2) == 0);
			end
		end
		s_tvalid <= 1'b0;
		while (pending_dots.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
		end
		if (results_seen >= next_hold_at && hold_left == 0) begin
			hold_left <= 150;
			next_hold_at <= next_hold_at + 600;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 80);
			end
			mode_left = mode_left - 1;
			if (ready_mode == 0) begin
				m_tready <= 1'b1;
			end else if (ready_mode == 1) begin
				m_tready <= 1'($urandom_range(0, 1));
			end else begin
				m_tready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_dots.size() == 0) begin
				$error("result with no pixel request waiting");
				fail_count++;
			end else begin
				oldest_dot = pending_dots.pop_front();
				if (m_tdata[0] !== oldest_dot.dot) begin
					$error("dot: expected %0b, got %0b", oldest_dot.dot, m_tdata[0]);
					fail_count++;
				end
				if (m_tlast !== oldest_dot.row_end) begin
					$error("row_end: expected %0b, got %0b", oldest_dot.row_end, m_tlast);
					fail_count++;
				end
			end
		end
	end

endmodule

/* filelist.f */
design/edd_pkg.sv
design/edd_kernel.sv
design/error_diffusion_dither.sv
tb/sv/error_diffusion_dither_test.sv
